/* src/fpsb_pkg.sv */
// ----------------------------------------------------------------------------
// fpsb_pkg
// Shared types and constants of the floating-point unit scoreboard.
// ----------------------------------------------------------------------------
package fpsb_pkg;

    localparam int NUM_UNITS = 6;
    localparam int LAT_W     = 5;
    localparam int FP_REGS   = 16;
    localparam int FPW       = $clog2(FP_REGS);

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_MUL   = 3'd1;
    localparam logic [2:0] OP_DIV   = 3'd2;
    localparam logic [2:0] OP_LOAD  = 3'd3;
    localparam logic [2:0] OP_STORE = 3'd4;

    localparam logic [2:0] NO_UNIT = 3'd7;

    localparam logic [1:0] REG_ADD_LAT = 2'd0;
    localparam logic [1:0] REG_MUL_LAT = 2'd1;
    localparam logic [1:0] REG_DIV_LAT = 2'd2;
    localparam logic [1:0] REG_MEM_LAT = 2'd3;

    localparam logic [1:0] ST_WAIT_OPS = 2'd0;
    localparam logic [1:0] ST_EXEC     = 2'd1;
    localparam logic [1:0] ST_WRITE    = 2'd2;

    typedef logic [NUM_UNITS-1:0] t_mask;

    // Controller to datapath: table advance and output register load, else hold.
    typedef struct packed {
        logic step;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic busy_any;
    } t_status;

endpackage

/* src/fpsb_ctrl.sv */
// ----------------------------------------------------------------------------
// fpsb_ctrl
// Handshake controller: take a tick when the result register is free or being read out.
// ----------------------------------------------------------------------------
module fpsb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  fpsb_pkg::t_status i_status,
    output fpsb_pkg::t_cmd    o_cmd
);
    import fpsb_pkg::*;

    localparam logic S_EMPTY = 1'b0;
    localparam logic S_FULL  = 1'b1;

    logic r_state, n_state;

    assign s_axis_tready = (r_state == S_EMPTY) || m_axis_tready;
    assign m_axis_tvalid = (r_state == S_FULL);
    assign o_cmd.step    = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EMPTY: if (o_cmd.step) n_state = S_FULL;
            S_FULL: begin
                if (m_axis_tready && !o_cmd.step) n_state = S_EMPTY;
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_EMPTY;
        else          r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_step_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> m_axis_tvalid) else $error("result not presented");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("tick taken while result stalled");
    a_busy_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(i_status.busy_any)) else $error("status unknown");
`endif

endmodule

/* src/fpsb_dp.sv */
// ----------------------------------------------------------------------------
// fpsb_dp
// Scoreboard tables: unit status, register result status and result register.
// ----------------------------------------------------------------------------
module fpsb_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fpsb_pkg::t_cmd   i_cmd,
    output fpsb_pkg::t_status o_status,
    input  logic [11:0]      i_tdata,
    input  logic             i_imm,
    input  logic [5:0]       i_sb,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [4:0]       i_cfg_data,
    output logic [31:0]      o_tdata
);
    import fpsb_pkg::*;

    logic [LAT_W-1:0] r_lat [4];

    logic [NUM_UNITS-1:0] r_busy, r_rdy_a, r_rdy_b, r_imm;
    logic [1:0]  r_stage [NUM_UNITS];
    logic [2:0]  r_opc   [NUM_UNITS];
    logic [FPW-1:0] r_dst [NUM_UNITS];
    logic [FPW-1:0] r_sa  [NUM_UNITS];
    logic [5:0]  r_sb    [NUM_UNITS];
    logic [2:0]  r_tag_a [NUM_UNITS];
    logic [2:0]  r_tag_b [NUM_UNITS];
    logic [LAT_W-1:0] r_cnt [NUM_UNITS];
    logic [2:0]  r_owner [FP_REGS];
    logic [31:0] r_out;

    logic       in_cmd, in_imm;
    logic [2:0] in_op;
    logic [3:0] in_dst_raw, in_sa_raw;
    logic [5:0] in_sb;
    logic [FPW-1:0] d_idx, a_idx, b_idx;
    logic       b_fp;
    t_mask      rmask, emask, wmask, bmask;
    logic       issue;
    logic [2:0] chosen, tag_a, tag_b;

    assign in_cmd     = i_tdata[0];
    assign in_op      = i_tdata[3:1];
    assign in_dst_raw = i_tdata[7:4];
    assign in_sa_raw  = i_tdata[11:8];
    assign in_sb      = i_sb;
    assign in_imm     = i_imm;

    assign o_status.busy_any = |r_busy;
    assign o_tdata           = r_out;

    always_comb begin
        d_idx = FPW'(in_dst_raw % FP_REGS);
        a_idx = FPW'(in_sa_raw % FP_REGS);
        b_fp  = 32'(in_sb) < FP_REGS;
        b_idx = FPW'(in_sb);
    end

    always_comb begin
        rmask = '0; emask = '0; wmask = '0;
        for (int i = 0; i < NUM_UNITS; i++) begin
            logic blk;
            blk = 1'b0;
            for (int j = 0; j < NUM_UNITS; j++) begin
                if (j != i && r_busy[j] && r_stage[j] == ST_WAIT_OPS) begin
                    if (!r_imm[j] && r_rdy_a[j] && r_sa[j] == r_dst[i]) blk = 1'b1;
                    if (32'(r_sb[j]) < FP_REGS && r_rdy_b[j]
                        && r_sb[j] == 6'(r_dst[i])) blk = 1'b1;
                end
            end
            if (r_busy[i]) begin
                if (r_stage[i] == ST_WAIT_OPS && r_rdy_a[i] && r_rdy_b[i])
                    rmask[i] = 1'b1;
                else if (r_stage[i] == ST_EXEC && r_cnt[i] == '0)
                    emask[i] = 1'b1;
                else if (r_stage[i] == ST_WRITE && !blk)
                    wmask[i] = 1'b1;
            end
        end
    end

    always_comb begin
        issue  = 1'b0;
        chosen = 3'd0;
        tag_a  = NO_UNIT;
        tag_b  = NO_UNIT;
        if (in_cmd && in_op <= OP_STORE && r_owner[d_idx] == NO_UNIT) begin
            case (in_op)
                OP_ADD: begin
                    if (!r_busy[0]) begin issue = 1'b1; chosen = 3'd0; end
                    else if (!r_busy[1]) begin issue = 1'b1; chosen = 3'd1; end
                end
                OP_MUL: begin
                    if (!r_busy[2]) begin issue = 1'b1; chosen = 3'd2; end
                    else if (!r_busy[3]) begin issue = 1'b1; chosen = 3'd3; end
                end
                OP_DIV: begin
                    if (!r_busy[4]) begin issue = 1'b1; chosen = 3'd4; end
                end
                default: begin
                    if (!r_busy[5]) begin issue = 1'b1; chosen = 3'd5; end
                end
            endcase
            if (!in_imm) tag_a = r_owner[a_idx];
            if (b_fp)    tag_b = r_owner[b_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat[0] <= 5'd3; r_lat[1] <= 5'd5; r_lat[2] <= 5'd11; r_lat[3] <= 5'd2;
        end else if (i_cfg_we) begin
            r_lat[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_rdy_a <= '0;
            r_rdy_b <= '0;
            r_imm   <= '0;
            for (int i = 0; i < NUM_UNITS; i++) begin
                r_stage[i] <= ST_WAIT_OPS;
                r_cnt[i]   <= '0;
            end
            for (int r = 0; r < FP_REGS; r++) r_owner[r] <= NO_UNIT;
        end else if (i_cmd.step) begin
            logic [NUM_UNITS-1:0] busy_n, ra_n, rb_n;
            logic [2:0] ta_n [NUM_UNITS];
            logic [2:0] tb_n [NUM_UNITS];
            busy_n = r_busy; ra_n = r_rdy_a; rb_n = r_rdy_b;
            for (int i = 0; i < NUM_UNITS; i++) begin
                ta_n[i] = r_tag_a[i];
                tb_n[i] = r_tag_b[i];
            end
            for (int i = 0; i < NUM_UNITS; i++) begin
                if (r_busy[i]) begin
                    if (r_stage[i] == ST_EXEC) begin
                        if (emask[i]) r_stage[i] <= ST_WRITE;
                        else r_cnt[i] <= r_cnt[i] - 1'b1;
                    end else if (rmask[i]) begin
                        r_stage[i] <= ST_EXEC;
                        case (r_opc[i])
                            OP_ADD:  r_cnt[i] <= r_lat[REG_ADD_LAT];
                            OP_MUL:  r_cnt[i] <= r_lat[REG_MUL_LAT];
                            OP_DIV:  r_cnt[i] <= r_lat[REG_DIV_LAT];
                            default: r_cnt[i] <= r_lat[REG_MEM_LAT];
                        endcase
                    end else if (wmask[i]) begin
                        busy_n[i] = 1'b0; ra_n[i] = 1'b0; rb_n[i] = 1'b0;
                        r_stage[i] <= ST_WAIT_OPS;
                        r_cnt[i] <= '0;
                    end
                end
            end
            for (int r = 0; r < FP_REGS; r++) begin
                for (int i = 0; i < NUM_UNITS; i++)
                    if (wmask[i] && r_dst[i] == FPW'(r) && r_owner[r] == 3'(i))
                        r_owner[r] <= NO_UNIT;
                if (issue && d_idx == FPW'(r)) r_owner[r] <= chosen;
            end
            if (issue) begin
                busy_n[chosen] = 1'b1;
                ra_n[chosen]   = (tag_a == NO_UNIT);
                rb_n[chosen]   = (tag_b == NO_UNIT);
                ta_n[chosen]   = tag_a;
                tb_n[chosen]   = tag_b;
                r_stage[chosen] <= ST_WAIT_OPS;
                r_cnt[chosen]   <= '0;
                r_opc[chosen]   <= in_op;
                r_dst[chosen]   <= d_idx;
                r_sa[chosen]    <= in_imm ? FPW'(in_sa_raw) : a_idx;
                r_sb[chosen]    <= in_sb;
                r_imm[chosen]   <= in_imm;
            end
            for (int k = 0; k < NUM_UNITS; k++) begin
                if (busy_n[k]) begin
                    if (!ra_n[k] && ta_n[k] != NO_UNIT && wmask[ta_n[k]]) begin
                        ra_n[k] = 1'b1; ta_n[k] = NO_UNIT;
                    end
                    if (!rb_n[k] && tb_n[k] != NO_UNIT && wmask[tb_n[k]]) begin
                        rb_n[k] = 1'b1; tb_n[k] = NO_UNIT;
                    end
                end
                r_tag_a[k] <= ta_n[k];
                r_tag_b[k] <= tb_n[k];
            end
            r_busy  <= busy_n;
            r_rdy_a <= ra_n;
            r_rdy_b <= rb_n;
        end
    end

    always_comb bmask = '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            logic [NUM_UNITS-1:0] b;
            b = r_busy & ~wmask;
            if (issue) b[chosen] = 1'b1;
            r_out <= {4'b0000, b | bmask, wmask, emask, rmask,
                      issue ? chosen : 3'd0, issue};
        end
    end

`ifndef SYNTHESIS
    a_wr_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wmask != '0) |-> ((wmask & ~r_busy) == '0)) else $error("idle write");
    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && issue) |-> !r_busy[chosen]) else $error("busy unit issued");
    a_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((rmask & emask) == '0) && ((emask & wmask) == '0))
        else $error("unit in two phases");
`endif

endmodule

/* src/fp_unit_scoreboard.sv */
// ----------------------------------------------------------------------------
// fp_unit_scoreboard
// Six-unit scoreboard: issue, operand read, countdown and write-back control.
//
//  channel   dir  tdata fields (low bit up)
//  s_axis    in   command, op, dest, src_a, src_b, immediate
//  m_axis    out  issued, issue_unit, read_mask, exec_done_mask,
//                 write_mask, busy_mask
//  cfg       in   latency registers: add, mul, div, mem
//
// One tick per cycle; the result register holds one transaction.
// All units advance in the cycle a tick is taken, from one registered table.
// Reset is synchronous; the latency registers reset to their add, mul, div and mem defaults.
// A stalled result holds the input side.
// ----------------------------------------------------------------------------
module fp_unit_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, op, dest, src_a, src_b, immediate
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // issued, issue_unit, read_mask, exec_done_mask, write_mask, busy_mask
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    import fpsb_pkg::*;

    t_cmd    cmd;
    t_status status;

    fpsb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
        .m_axis_tvalid, .m_axis_tready, .i_status(status), .o_cmd(cmd)
    );

    fpsb_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_tdata(s_axis_tdata[11:0]), .i_imm(s_axis_tdata[18]),
        .i_sb(s_axis_tdata[17:12]),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_tdata(m_axis_tdata)
    );

endmodule
